// ===== src/mbps_pkg.sv =====
// Package for the masked byte pattern scanner.
// Holds the register map, port field widths and the per-cell config strobe struct.
// No dependencies.
package mbps_pkg;

   // Configuration register map
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 64;
   localparam int PAT_REG_COUNT  = 7;
   localparam logic [CSR_INDEX_BITS-1:0] CARE_MASK_INDEX = CSR_INDEX_BITS'(PAT_REG_COUNT);
   localparam int BYTES_PER_REG  = 8;

   // Stream field widths
   localparam int REQ_DATA_BITS  = 8;
   localparam int REQ_USER_BITS  = 2;
   localparam int RSP_DATA_BITS  = 32;
   localparam int RSP_USER_BITS  = 2;

   // tuser bit positions
   localparam int REQ_USER_REGION = 0;
   localparam int REQ_USER_SCAN   = 1;
   localparam int RSP_USER_MATCH  = 0;
   localparam int RSP_USER_FOUND  = 1;

   // Config strobes and data handed to one window cell
   typedef struct packed {
      logic       pat_we;
      logic [7:0] pat_byte;
      logic       care_we;
      logic       care_bit;
   } cell_cfg_type;

endpackage

// ===== src/masked_byte_pattern_scanner.sv =====
// Top level of the masked byte pattern scanner.
// Shifts request bytes through a row of mbps_cell window cells; depends on mbps_pkg and mbps_cell.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------------------
//  req_    | in        | req_tvalid/req_tready | tdata: data_byte; tuser: region, scan
//  rsp_    | out       | rsp_tvalid/rsp_tready | tdata: match_offset; tuser: match, found
//  csr_    | in        | csr_valid/csr_ready   | csr_index, csr_data (always ready)
//
// One request per cycle sustained while responses drain; every accepted request yields
// one response, from the response register behind stage one.
// Stage one is the cell row plus fill and position counters, updated on accept; the
// compare of all cells and the found latch resolve into the response register.
// Two register stages; 56 byte compares feeding one AND reduction sit between them.
// A stalled response holds stage one; a request is taken while the response drains.
// Reset is synchronous, active high; it clears counters, valids, config and the latch.
module masked_byte_pattern_scanner import mbps_pkg::*; #(
   parameter int PATTERN_LEN = 56,
   parameter int OFFSET_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   // request stream
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_BITS-1:0]  req_tdata,   // [7:0] data_byte
   input  logic [REQ_USER_BITS-1:0]  req_tuser,   // [0] region_start, [1] scan_start
   // response stream
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata,   // [31:0] match_offset
   output logic [RSP_USER_BITS-1:0]  rsp_tuser,   // [0] match, [1] found
   // configuration writes
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int FILL_BITS = $clog2(PATTERN_LEN + 1);
   localparam logic [FILL_BITS-1:0]   FILL_FULL = FILL_BITS'(PATTERN_LEN);
   localparam logic [OFFSET_BITS-1:0] LEAD_BACK = OFFSET_BITS'(PATTERN_LEN - 1);

   logic req_fire, csr_fire, adv2, restart, window_full, window_ok;
   logic hit, found_prev;

   // stage one: cell row is held below, counters and item tags here
   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_scan_ff, s1_scan_in;
   logic [OFFSET_BITS-1:0] s1_pos_ff, s1_pos_in;
   logic [FILL_BITS-1:0]   fill_ff, fill_in;
   logic [OFFSET_BITS-1:0] region_pos_ff, region_pos_in;

   // stage two: response register and found latch
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   match_ff, match_in;
   logic                   found_ff, found_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic [63:0]            offset_wide;

   logic [7:0]         win   [PATTERN_LEN];
   logic [PATTERN_LEN-1:0] cell_ok;
   cell_cfg_type       cell_cfg [PATTERN_LEN];

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid & csr_ready;

   // advance stage one into the response register when it is free or draining
   assign adv2       = s1_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~s1_valid_ff | adv2;
   assign req_fire   = req_tvalid & req_tready;
   assign restart    = req_tuser[REQ_USER_REGION] | req_tuser[REQ_USER_SCAN];

   // row of cells: newest byte enters at the top, oldest sits in cell zero
   for (genvar j = 0; j < PATTERN_LEN; j++) begin : g_cell
      localparam logic [CSR_INDEX_BITS-1:0] REG_IDX = CSR_INDEX_BITS'(j / BYTES_PER_REG);
      localparam int LANE = j % BYTES_PER_REG;
      logic [7:0] cell_in;

      if (j == PATTERN_LEN - 1) begin : g_head
         assign cell_in = req_tdata[7:0];
      end else begin : g_link
         assign cell_in = win[j+1];
      end

      always_comb begin
         cell_cfg[j].pat_we   = csr_fire & (csr_index == REG_IDX);
         cell_cfg[j].pat_byte = csr_data[LANE*8 +: 8];
         cell_cfg[j].care_we  = csr_fire & (csr_index == CARE_MASK_INDEX);
         cell_cfg[j].care_bit = csr_data[j];
      end

      mbps_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (req_fire),
         .byte_in  (cell_in),
         .cfg      (cell_cfg[j]),
         .byte_out (win[j]),
         .cell_ok  (cell_ok[j])
      );
   end

   // stage one counters: a region or scan start restarts fill and position
   always_comb begin
      s1_valid_in   = req_fire | (s1_valid_ff & ~adv2);
      s1_scan_in    = s1_scan_ff;
      s1_pos_in     = s1_pos_ff;
      fill_in       = fill_ff;
      region_pos_in = region_pos_ff;
      if (req_fire) begin
         s1_scan_in = req_tuser[REQ_USER_SCAN];
         if (restart) begin
            s1_pos_in = '0;
            fill_in   = FILL_BITS'(1);
         end else begin
            s1_pos_in = region_pos_ff;
            fill_in   = (fill_ff == FILL_FULL) ? fill_ff : fill_ff + FILL_BITS'(1);
         end
         region_pos_in = s1_pos_in + OFFSET_BITS'(1);
      end
   end

   // compare of the whole window, gated by a full window of this region and the found latch
   assign window_full = (fill_ff == FILL_FULL);
   assign window_ok   = &cell_ok;
   assign found_prev  = found_ff & ~s1_scan_ff;
   assign hit         = ~found_prev & window_full & window_ok;

   always_comb begin
      rsp_valid_in = adv2 | (rsp_valid_ff & ~rsp_tready);
      match_in     = match_ff;
      found_in     = found_ff;
      offset_in    = offset_ff;
      if (adv2) begin
         match_in = hit;
         found_in = found_prev | hit;
         if (hit) begin
            // report where the signature starts, not where it ends
            offset_in = s1_pos_ff - LEAD_BACK;
         end else if (s1_scan_ff) begin
            offset_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         fill_ff       <= '0;
         region_pos_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         found_ff      <= 1'b0;
         offset_ff     <= '0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         fill_ff       <= fill_in;
         region_pos_ff <= region_pos_in;
         rsp_valid_ff  <= rsp_valid_in;
         found_ff      <= found_in;
         offset_ff     <= offset_in;
      end
   end

   // item tags and the match flag are payload
   always_ff @(posedge clock) begin
      s1_scan_ff <= s1_scan_in;
      s1_pos_ff  <= s1_pos_in;
      match_ff   <= match_in;
   end

   assign offset_wide = 64'(offset_ff);
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = offset_wide[RSP_DATA_BITS-1:0];
   always_comb begin
      rsp_tuser                 = '0;
      rsp_tuser[RSP_USER_MATCH] = match_ff;
      rsp_tuser[RSP_USER_FOUND] = found_ff;
   end

endmodule

// ===== src/mbps_cell.sv =====
// One window cell of the masked byte pattern scanner.
// Holds one window byte, its signature byte and care bit; depends on mbps_pkg.
module mbps_cell import mbps_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         shift_en,
   input  logic [7:0]   byte_in,
   input  cell_cfg_type cfg,
   output logic [7:0]   byte_out,
   output logic         cell_ok
);

   logic [7:0] win_ff, win_in;
   logic [7:0] pat_ff, pat_in;
   logic       care_ff, care_in;

   always_comb begin
      win_in  = shift_en ? byte_in : win_ff;
      pat_in  = cfg.pat_we ? cfg.pat_byte : pat_ff;
      care_in = cfg.care_we ? cfg.care_bit : care_ff;
   end

   // window byte is payload: the fill count gates any stale content
   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff  <= '0;
         care_ff <= 1'b0;
      end else begin
         pat_ff  <= pat_in;
         care_ff <= care_in;
      end
   end

   assign byte_out = win_ff;
   assign cell_ok  = ~care_ff | (win_ff == pat_ff);

endmodule

// ===== src/mbps_checker.sv =====
// Port-level checks for the masked byte pattern scanner, bound to the top level.
// Depends on mbps_pkg and masked_byte_pattern_scanner.
module mbps_checker import mbps_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [RSP_DATA_BITS-1:0]  rsp_tdata,
   input logic [RSP_USER_BITS-1:0]  rsp_tuser
);

   // a reported match always comes with the found flag set
   a_match_found: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[RSP_USER_MATCH] |-> rsp_tuser[RSP_USER_FOUND])
      else $error("match reported without found");

   // a free or draining response side never blocks requests
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("request stalled while response side free");

   // no response straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

endmodule

bind masked_byte_pattern_scanner mbps_checker u_mbps_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for masked_byte_pattern_scanner.
// Drives request bytes and register writes, predicts every response and checks it;
// depends on mbps_pkg and the scanner RTL only.
module tb;
   import mbps_pkg::*;

   localparam int SIG_LEN      = 56;
   localparam int NUM_PHASES   = 7;
   localparam int PHASE_BYTES  = 200;
   localparam int DRAIN_CYCLES = 4;     // response register sits behind the stage one register
   localparam int IDLE_LIMIT   = 1000;  // far above the longest sender gap plus receiver stall

   // One expected response: match pulse, latched offset and found flag
   typedef struct {
      bit        hit;
      bit [31:0] offset;
      bit        found;
   } scan_report_type;

   // Tracks the scanner state, queues the expected responses and checks the real ones
   class signature_tracker;
      bit [63:0]    pat_regs [PAT_REG_COUNT];
      bit [SIG_LEN-1:0] care;
      bit [7:0]     window [SIG_LEN];
      int           fill;
      bit [31:0]    position;
      bit           latched;
      bit [31:0]    latched_offset;
      scan_report_type pending_reports [$];
      int           errors;
      int           first_hits;
      int           bytes_seen;

      function void write_reg(bit [CSR_INDEX_BITS-1:0] index, bit [63:0] value);
         if (index < PAT_REG_COUNT)
            pat_regs[index] = value;
         else if (index == CARE_MASK_INDEX)
            care = value[SIG_LEN-1:0];
      endfunction

      function bit window_hits();
         for (int j = 0; j < SIG_LEN; j++) begin
            if (care[j] && window[j] != pat_regs[j / 8][(j % 8) * 8 +: 8])
               return 1'b0;
         end
         return 1'b1;
      endfunction

      function void note_byte(bit [7:0] data, bit region_start, bit scan_start);
         scan_report_type rep;
         bit [31:0]    pos;
         bytes_seen++;
         if (scan_start) begin
            latched        = 1'b0;
            latched_offset = '0;
         end
         if (region_start || scan_start) begin
            foreach (window[j]) window[j] = '0;
            fill     = 0;
            position = '0;
         end
         // oldest byte at index 0, newest at the top
         for (int j = 0; j < SIG_LEN - 1; j++)
            window[j] = window[j + 1];
         window[SIG_LEN - 1] = data;
         if (fill < SIG_LEN)
            fill++;
         pos      = position;
         position = position + 1;
         rep.hit  = 1'b0;
         if (!latched && fill == SIG_LEN && window_hits()) begin
            rep.hit        = 1'b1;
            latched        = 1'b1;
            latched_offset = pos - (SIG_LEN - 1);
            first_hits++;
         end
         rep.offset = latched_offset;
         rep.found  = latched;
         pending_reports = {pending_reports, rep};
      endfunction

      function void check_report(bit [31:0] offset, bit hit, bit found);
         scan_report_type want;
         if (pending_reports.size() == 0) begin
            $display("%0t: response with nothing expected: offset %h match %b found %b",
                     $time, offset, hit, found);
            errors++;
            return;
         end
         want = pending_reports.pop_front();
         if (want.hit != hit) begin
            $display("%0t: match expected %b got %b", $time, want.hit, hit);
            errors++;
         end
         if (want.offset != offset) begin
            $display("%0t: match_offset expected %h got %h", $time, want.offset, offset);
            errors++;
         end
         if (want.found != found) begin
            $display("%0t: found expected %b got %b", $time, want.found, found);
            errors++;
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_BITS-1:0]  req_tdata  = '0;
   logic [REQ_USER_BITS-1:0]  req_tuser  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   logic [RSP_USER_BITS-1:0]  rsp_tuser;
   logic                      csr_valid  = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index  = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data   = '0;

   signature_tracker tracker = new;

   // Signature as last programmed, used to build matching regions
   bit [7:0]         sig_bytes [SIG_LEN];
   bit [SIG_LEN-1:0] sig_care;
   bit               req_burst;
   int               idle_cycles;
   bit               active;

   masked_byte_pattern_scanner i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Monitor: every value read here is the one held just before the edge, so the
   // order of processes within the step does not matter.
   always @(posedge clock) begin
      if (!reset) begin
         active = 1'b0;
         if (csr_valid && csr_ready) begin
            tracker.write_reg(csr_index, csr_data);
            active = 1'b1;
         end
         if (req_tvalid && req_tready) begin
            tracker.note_byte(req_tdata, req_tuser[REQ_USER_REGION], req_tuser[REQ_USER_SCAN]);
            active = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            tracker.check_report(rsp_tdata, rsp_tuser[RSP_USER_MATCH], rsp_tuser[RSP_USER_FOUND]);
            active = 1'b1;
         end
         // Watchdog: give up when nothing moves on any channel for too long
         idle_cycles = active ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // Response side: hold ready low for a random gap before each response, with
   // stretches of full-rate draining in between.
   initial begin
      bit rsp_burst;
      int gap;
      int served;
      rsp_burst = 1'b0;
      served    = 0;
      while (reset) @(posedge clock);
      forever begin
         if (served % 32 == 0)
            rsp_burst = ($urandom_range(0, 3) == 0);
         gap = rsp_burst ? 0 : $urandom_range(0, 9);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         served++;
      end
   end

   // Present one register write and hold it until taken; the caller drops valid
   task automatic write_csr(input bit [CSR_INDEX_BITS-1:0] index, input bit [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Present one request after a random gap and hold it until accepted; valid is
   // left high so that back-to-back requests stream without a bubble.
   task automatic send_request(input bit [7:0] data, input bit [REQ_USER_BITS-1:0] user);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= user;
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop valid and wait until every response is back, then let the pipe settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (tracker.pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Program all seven pattern registers and the care mask, then one random index past the map
   task automatic program_signature(input int phase);
      bit [63:0]        value;
      bit [SIG_LEN-1:0] mask;
      for (int r = 0; r < PAT_REG_COUNT; r++) begin
         value = {$urandom, $urandom};
         if (phase == 1)
            value = '1;
         else if (phase == 5)
            value = '0;
         for (int b = 0; b < BYTES_PER_REG; b++)
            sig_bytes[r * BYTES_PER_REG + b] = value[b * 8 +: 8];
         write_csr(CSR_INDEX_BITS'(r), value);
      end
      case (phase % 4)
         0: mask = '0;                      // every byte a wildcard
         1: mask = '1;                      // every byte cared for
         2: begin                           // a handful of cared bytes
            mask = '0;
            repeat (6) mask[$urandom_range(0, SIG_LEN - 1)] = 1'b1;
         end
         default: mask = SIG_LEN'({$urandom, $urandom});
      endcase
      sig_care = mask;
      // junk in the top byte must be dropped by the block
      write_csr(CARE_MASK_INDEX, {8'($urandom_range(0, 255)), mask});
      write_csr(CSR_INDEX_BITS'($urandom_range(CARE_MASK_INDEX + 1, (1 << CSR_INDEX_BITS) - 1)),
                {$urandom, $urandom});
      csr_valid <= 1'b0;
   endtask

   // Feed regions until the phase has its share of bytes: mostly regions that carry
   // the signature (some with one cared byte broken), plus short and noise regions.
   task automatic run_phase();
      bit [7:0]                 region_bytes [128];
      bit [REQ_USER_BITS-1:0]   user;
      int                       count;
      int                       len;
      int                       kind;
      int                       k;
      int                       j;
      count = 0;
      while (count < PHASE_BYTES) begin
         req_burst = ($urandom_range(0, 3) == 0);
         kind      = $urandom_range(0, 9);
         if (kind < 2)
            len = $urandom_range(1, SIG_LEN - 1);
         else if (kind < 8)
            len = $urandom_range(SIG_LEN, SIG_LEN + 44);
         else
            len = $urandom_range(SIG_LEN, 120);
         for (int i = 0; i < len; i++)
            region_bytes[i] = 8'($urandom_range(0, 255));
         if (kind >= 2 && kind < 8) begin
            k = $urandom_range(0, len - SIG_LEN);
            for (int i = 0; i < SIG_LEN; i++)
               if (sig_care[i]) region_bytes[k + i] = sig_bytes[i];
            if ($urandom_range(0, 3) == 0 && sig_care != '0) begin
               do j = $urandom_range(0, SIG_LEN - 1); while (!sig_care[j]);
               region_bytes[k + j] = ~sig_bytes[j];
            end
         end
         // open with a region start, a scan start or both
         user = REQ_USER_BITS'($urandom_range(1, 3));
         for (int i = 0; i < len; i++)
            send_request(region_bytes[i], (i == 0) ? user : '0);
         count += len;
      end
   endtask

   initial begin
      bit [REQ_USER_BITS-1:0] scan_user;
      bit [REQ_USER_BITS-1:0] region_user;
      scan_user   = '0;
      region_user = '0;
      scan_user[REQ_USER_SCAN]     = 1'b1;
      region_user[REQ_USER_REGION] = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: byte extremes, every start combination, regions too short to match
      req_burst = 1'b1;
      send_request(8'h00, scan_user);
      send_request(8'hFF, '0);
      send_request(8'h80, '0);
      send_request(8'h01, '0);
      send_request(8'hAA, region_user);
      send_request(8'h55, '0);
      send_request(8'h7F, scan_user | region_user);
      send_request(8'hFE, region_user);
      send_request(8'h00, region_user);
      req_burst = 1'b0;
      send_request(8'hFF, scan_user);
      for (int i = 0; i < 10; i++)
         send_request(8'(i * 29), '0);
      drain();

      // Random phases over a range of signatures and care masks
      for (int p = 0; p < NUM_PHASES; p++) begin
         program_signature(p);
         run_phase();
         drain();
      end

      $display("Scanned %0d bytes over %0d signature settings; %0d first matches reported.",
               tracker.bytes_seen, NUM_PHASES, tracker.first_hits);
      if (tracker.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== files.f =====
src/mbps_pkg.sv
src/mbps_cell.sv
src/masked_byte_pattern_scanner.sv
src/mbps_checker.sv
tb/tb.sv
